@@ sv/tcq_pkg.sv @@
// Shared codes and interface types of the two-class ticket queue.
package tcq_pkg;

    // Action codes carried on the action input.
    localparam logic [2:0] ACT_ISSUE      = 3'd0;
    localparam logic [2:0] ACT_INSERT     = 3'd1;
    localparam logic [2:0] ACT_POP_HEAD   = 3'd2;
    localparam logic [2:0] ACT_POP_NORMAL = 3'd3;
    localparam logic [2:0] ACT_POP_PREF   = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // Ticket classes.
    localparam logic CLS_NORMAL = 1'b0;
    localparam logic CLS_PREF   = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;    // capture operands and build the match vector
        logic       head;    // match every held slot
        logic       want;    // class to match when head is low
        logic       exec;    // commit the captured action this cycle
        logic       push;    // enqueue a ticket at the tail
        logic       issue;   // pushed number comes from the issue counter
        logic       pop;     // remove the first matching slot
        logic [1:0] status;  // status code reported with the result
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;   // every slot is held
        logic found;  // the match vector has at least one bit set
    } t_dp_stat;

endpackage

@@ sv/tcq_ctrl.sv @@
// Controller state machine of the two-class ticket queue.
module tcq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [2:0]        i_action,
    input  tcq_pkg::t_dp_stat i_stat,
    output tcq_pkg::t_ctrl_cmd o_cmd,
    output logic              busy,
    output logic              o_valid
);
    import tcq_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic       r_state;
    logic       n_state;
    logic [2:0] r_act;
    logic       r_valid;
    logic       accept;
    logic       is_push;
    logic       is_pop;
    logic       push_ok;
    logic       pop_ok;

    assign busy    = (r_state == S_EXEC);
    assign o_valid = r_valid;
    assign accept  = start && !busy;

    assign is_push = (r_act == ACT_ISSUE) || (r_act == ACT_INSERT);
    assign is_pop  = (r_act == ACT_POP_HEAD) || (r_act == ACT_POP_NORMAL) ||
                     (r_act == ACT_POP_PREF);
    assign push_ok = is_push && !i_stat.full;
    assign pop_ok  = is_pop && i_stat.found;

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = accept;
        o_cmd.head   = (i_action == ACT_POP_HEAD);
        o_cmd.want   = (i_action == ACT_POP_PREF) ? CLS_PREF : CLS_NORMAL;
        o_cmd.exec   = busy;
        o_cmd.push   = busy && push_ok;
        o_cmd.issue  = (r_act == ACT_ISSUE);
        o_cmd.pop    = busy && pop_ok;
        if (is_push && i_stat.full) begin
            o_cmd.status = ST_FULL;
        end else if (push_ok || pop_ok) begin
            o_cmd.status = ST_DONE;
        end else begin
            o_cmd.status = ST_MISS;
        end
    end

    always_comb begin
        unique case (r_state)
            S_IDLE:  n_state = accept ? S_EXEC : S_IDLE;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act <= i_action;
        end
    end

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transfer did not enter execution");

    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_valid && !busy))
        else $error("execution did not produce exactly one result");

    a_no_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.push && o_cmd.pop))
        else $error("push and pop commanded together");

endmodule

@@ sv/tcq_dp.sv @@
// Datapath of the two-class ticket queue: slot row, match vector and result registers.
module tcq_dp #(
    parameter int QUEUE_DEPTH = 16,
    parameter int NUMBER_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tcq_pkg::t_ctrl_cmd               i_cmd,
    input  logic                             i_ticket_class,
    input  logic [NUMBER_BITS-1:0]           i_ticket_number,
    output tcq_pkg::t_dp_stat                o_stat,
    output logic [1:0]                       o_status,
    output logic                             o_out_class,
    output logic [NUMBER_BITS-1:0]           o_out_number,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] o_occupancy
);
    import tcq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = $clog2(QUEUE_DEPTH);

    logic [QUEUE_DEPTH-1:0] r_cls;
    logic [NUMBER_BITS-1:0] r_num [QUEUE_DEPTH];
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic [NUMBER_BITS-1:0] r_ctr;
    logic [QUEUE_DEPTH-1:0] r_match;
    logic                   r_in_cls;
    logic [NUMBER_BITS-1:0] r_in_num;

    logic [1:0]             r_status;
    logic                   r_out_cls;
    logic [NUMBER_BITS-1:0] r_out_num;
    logic [CW-1:0]          r_occ;

    logic [QUEUE_DEPTH-1:0] first;
    logic [QUEUE_DEPTH-1:0] at_or_after;
    logic                   sel_cls;
    logic [NUMBER_BITS-1:0] sel_num;
    logic [NUMBER_BITS-1:0] push_num;
    logic                   res_cls;
    logic [NUMBER_BITS-1:0] res_num;

    assign o_stat.full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_stat.found = |r_match;

    // Isolate the oldest matching slot and mark it and every younger slot.
    assign first       = r_match & (~r_match + QUEUE_DEPTH'(1));
    assign at_or_after = ~(first - QUEUE_DEPTH'(1));

    always_comb begin
        sel_num = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            sel_num = sel_num | (r_num[i] & {NUMBER_BITS{first[i]}});
        end
    end
    assign sel_cls = |(first & r_cls);

    assign push_num = i_cmd.issue ? (r_ctr + NUMBER_BITS'(2)) : r_in_num;

    always_comb begin
        n_count = r_count;
        res_cls = 1'b0;
        res_num = '0;
        if (i_cmd.push) begin
            n_count = r_count + CW'(1);
            res_cls = r_in_cls;
            res_num = push_num;
        end else if (i_cmd.pop) begin
            n_count = r_count - CW'(1);
            res_cls = sel_cls;
            res_num = sel_num;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ctr   <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
            if (i_cmd.push && i_cmd.issue) begin
                r_ctr <= r_ctr + NUMBER_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in_cls <= i_ticket_class;
            r_in_num <= i_ticket_number;
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                r_match[i] <= (CW'(i) < r_count) && (i_cmd.head || (r_cls[i] == i_cmd.want));
            end
        end
        if (i_cmd.push) begin
            r_cls[r_count[IW-1:0]] <= r_in_cls;
            r_num[r_count[IW-1:0]] <= push_num;
        end else if (i_cmd.pop) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                if (at_or_after[i]) begin
                    r_cls[i] <= r_cls[i+1];
                    r_num[i] <= r_num[i+1];
                end
            end
        end
        if (i_cmd.exec) begin
            r_status  <= i_cmd.status;
            r_out_cls <= res_cls;
            r_out_num <= res_num;
            r_occ     <= n_count;
        end
    end

    assign o_status     = r_status;
    assign o_out_class  = r_out_cls;
    assign o_out_number = r_out_num;
    assign o_occupancy  = r_occ;

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |=> (r_count == $past(r_count) - CW'(1)))
        else $error("pop did not shrink the queue by one");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not grow the queue by one");

    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> (r_count <= CW'(QUEUE_DEPTH)))
        else $error("held count exceeds queue depth");

endmodule

@@ sv/two_class_ticket_queue.sv @@
// Top level of the two-class ticket queue: controller plus datapath.
//
// A bounded queue of tickets kept in arrival order; each ticket carries a class
// (normal or preferential) and a number. A command transfer is taken at a rising
// edge with start high and busy low. On that edge the operands are captured and
// a per-slot match vector (held slots of the wanted class, or all held slots for
// a head removal) is registered. On the next edge busy is high and the action
// commits: a push writes the tail slot, a removal picks the oldest matching slot
// by find-first and shifts every younger slot down by one, so arrival order is
// kept. The result appears for exactly one cycle after that, marked by o_valid,
// and the receiver cannot hold it off. Every command therefore passes
// through the match register and then the commit step; a new command
// may be started in the cycle that the previous result is shown. A full queue
// rejects issue and insert with status 2 and leaves the issue counter alone; an
// empty queue, a missing class or an unused action code reports status 1. When
// the status is not 0 the ticket class and number outputs are zero. o_occupancy
// gives the number of tickets held after the action.
module two_class_ticket_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int NUMBER_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [2:0]                       i_action,
    input  logic                             i_ticket_class,
    input  logic [NUMBER_BITS-1:0]           i_ticket_number,
    output logic                             o_valid,
    output logic [1:0]                       o_status,
    output logic                             o_out_class,
    output logic [NUMBER_BITS-1:0]           o_out_number,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] o_occupancy
);
    import tcq_pkg::*;

    // Commands flow from the controller; full and found flow back.
    t_ctrl_cmd cmd;
    t_dp_stat  stat;

    tcq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_action),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_valid  (o_valid)
    );

    // The datapath holds the slot row, the issue counter and the result registers.
    tcq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NUMBER_BITS (NUMBER_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_ticket_class  (i_ticket_class),
        .i_ticket_number (i_ticket_number),
        .o_stat          (stat),
        .o_status        (o_status),
        .o_out_class     (o_out_class),
        .o_out_number    (o_out_number),
        .o_occupancy     (o_occupancy)
    );

endmodule
